// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the tone sequence player RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define TSP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that an event in one cycle implies a condition in the next.
`define TSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tsp_pkg.sv -----
// Package of the tone sequence player: command codes, step codes, types.
// Depends on nothing; used by the front, divider, back end, top level and testbench.
package tsp_pkg;

   localparam int STEP_DEPTH_DEF  = 256;
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam logic [15:0] STOP_CODE = 16'd0;
   localparam logic [15:0] LOOP_CODE = 16'hFFFF;
   localparam logic [31:0] CLOCK_HZ_RESET = 32'd80000000;
   localparam int FRONT_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_PLAY  = 2'd2,
      CMD_STOP  = 2'd3
   } cmd_code_type;

   localparam logic [1:0] MODE_FORCE = 2'd0;
   localparam logic [1:0] MODE_QUEUE = 2'd1;

   typedef struct packed {
      cmd_code_type cmd;
      logic [1:0]   mode;
      logic [7:0]   start;
      logic [7:0]   addr;
      logic [15:0]  action;
      logic [15:0]  freq;
      logic         clr;
   } cmd_type;

   typedef struct packed {
      logic        accepted;
      logic        busy;
      logic        tone_enable;
      logic [31:0] period;
      logic [30:0] match;
      logic [3:0]  queued;
   } result_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_STEP_RD,
      ST_STEP_EX,
      ST_LOOP_RD,
      ST_LOOP_EX,
      ST_QUEUE_RD,
      ST_QUEUE_EX,
      ST_DIVIDE,
      ST_RESP
   } back_state_type;

endpackage

// ----- rtl/core/tsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/tsp_front.sv -----
// Front end: takes request beats, decodes them and buffers them for the back end.
// Depends on tsp_pkg.
module tsp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [55:0]      req_tdata,
   input  logic [1:0]       req_tuser,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output tsp_pkg::cmd_type cmd_item
);
   tsp_pkg::cmd_type buf_ff [tsp_pkg::FRONT_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   tsp_pkg::cmd_type dec;

   always_comb begin
      dec.cmd    = tsp_pkg::cmd_code_type'(req_tuser);
      dec.mode   = req_tdata[1:0];
      dec.start  = req_tdata[9:2];
      dec.addr   = req_tdata[17:10];
      dec.action = req_tdata[33:18];
      dec.freq   = req_tdata[49:34];
      dec.clr    = req_tdata[50];
   end

   assign req_tready = (count_ff != 2'(tsp_pkg::FRONT_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd_item   = buf_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule

// ----- rtl/core/tsp_div.sv -----
// Restoring divider, one quotient bit per cycle, 32-bit by 16-bit.
// Depends on tsp_pkg.
module tsp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tsp_pkg::div_req_type req,
   output tsp_pkg::div_rsp_type rsp
);
   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [16:0] trial;
   logic        fits;

   assign trial = {rem_ff, quo_ff[31]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = 16'd0;
         dvs_in  = req.divisor;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? 16'(trial - {1'b0, dvs_ff}) : trial[15:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

// ----- rtl/core/tsp_back.sv -----
// Back end: sequencer that runs commands against the step memory and start queue.
// Depends on tsp_pkg, tsp_ram, tsp_div and assert_macros.svh.
`include "assert_macros.svh"

module tsp_back #(
   parameter int STEP_DEPTH  = tsp_pkg::STEP_DEPTH_DEF,
   parameter int QUEUE_DEPTH = tsp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         clock_hz,
   input  logic                cmd_valid,
   output logic                cmd_pop,
   input  tsp_pkg::cmd_type    cmd_item,
   output logic                res_valid,
   input  logic                res_ready,
   output tsp_pkg::result_type res_data
);
   localparam int SAW = $clog2(STEP_DEPTH);
   localparam int SW  = (SAW > 9) ? SAW : 9;
   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QFW = $clog2(QUEUE_DEPTH + 1);

   tsp_pkg::back_state_type state_ff, state_in;
   tsp_pkg::cmd_type cmd_ff, cmd_in;
   logic [7:0]     seq_ff, seq_in, off_ff, off_in;
   logic [15:0]    loop_ff, loop_in, rem_ff, rem_in, freq_ff, freq_in;
   logic [31:0]    period_ff, period_in;
   logic           playing_ff, playing_in, acc_ff, acc_in;
   logic [QAW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [QFW-1:0] fill_ff, fill_in;
   logic           out_valid_ff, out_valid_in;
   tsp_pkg::result_type out_ff, out_in;

   logic           step_we, q_we;
   logic [SAW-1:0] step_waddr, step_raddr;
   logic [31:0]    step_rdata;
   logic [7:0]     q_rdata;
   logic [SW-1:0]  seq_sum;
   logic [15:0]    rd_action, rd_freq, loop_next;
   tsp_pkg::div_req_type div_req;
   tsp_pkg::div_rsp_type div_rsp;

   function automatic logic [QAW-1:0] q_next(input logic [QAW-1:0] p);
      return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + QAW'(1);
   endfunction

   assign seq_sum    = SW'(seq_ff) + SW'(off_ff);
   assign step_raddr = seq_sum[SAW-1:0];
   assign step_waddr = SAW'(SW'(cmd_ff.addr));
   assign rd_action  = step_rdata[15:0];
   assign rd_freq    = step_rdata[31:16];
   assign loop_next  = loop_ff + 16'd1;

   tsp_ram #(.WIDTH(32), .DEPTH(STEP_DEPTH)) u_step_ram (
      .clock   (clock),
      .wr_en   (step_we),
      .wr_addr (step_waddr),
      .wr_data ({cmd_ff.freq, cmd_ff.action}),
      .rd_addr (step_raddr),
      .rd_data (step_rdata)
   );

   tsp_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (tail_ff),
      .wr_data (cmd_ff.start),
      .rd_addr (head_ff),
      .rd_data (q_rdata)
   );

   tsp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsp_pkg::ST_IDLE: begin
            if (cmd_valid && !out_valid_ff) state_in = tsp_pkg::ST_EXEC;
         end
         tsp_pkg::ST_EXEC: begin
            state_in = tsp_pkg::ST_RESP;
            unique case (cmd_ff.cmd)
               tsp_pkg::CMD_TICK: begin
                  if (playing_ff && rem_ff <= 16'd1) state_in = tsp_pkg::ST_STEP_RD;
               end
               tsp_pkg::CMD_PLAY: begin
                  if (cmd_ff.mode == tsp_pkg::MODE_FORCE || !playing_ff) begin
                     state_in = tsp_pkg::ST_STEP_RD;
                  end
               end
               default: state_in = tsp_pkg::ST_RESP;
            endcase
         end
         tsp_pkg::ST_STEP_RD: state_in = tsp_pkg::ST_STEP_EX;
         tsp_pkg::ST_STEP_EX: begin
            priority if (rd_action == tsp_pkg::STOP_CODE ||
                         (rd_action == tsp_pkg::LOOP_CODE && rd_freq != 16'd0 &&
                          loop_next == rd_freq)) begin
               state_in = (fill_ff == '0) ? tsp_pkg::ST_RESP : tsp_pkg::ST_QUEUE_RD;
            end else if (rd_action == tsp_pkg::LOOP_CODE) begin
               state_in = tsp_pkg::ST_LOOP_RD;
            end else begin
               state_in = (rd_freq == 16'd0) ? tsp_pkg::ST_RESP : tsp_pkg::ST_DIVIDE;
            end
         end
         tsp_pkg::ST_LOOP_RD: state_in = tsp_pkg::ST_LOOP_EX;
         tsp_pkg::ST_LOOP_EX: begin
            state_in = (rd_freq == 16'd0) ? tsp_pkg::ST_RESP : tsp_pkg::ST_DIVIDE;
         end
         tsp_pkg::ST_QUEUE_RD: state_in = tsp_pkg::ST_QUEUE_EX;
         tsp_pkg::ST_QUEUE_EX: state_in = tsp_pkg::ST_STEP_RD;
         tsp_pkg::ST_DIVIDE: begin
            if (div_rsp.done) state_in = tsp_pkg::ST_RESP;
         end
         tsp_pkg::ST_RESP: state_in = tsp_pkg::ST_IDLE;
         default: state_in = tsp_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cmd_in       = cmd_ff;
      seq_in       = seq_ff;
      off_in       = off_ff;
      loop_in      = loop_ff;
      rem_in       = rem_ff;
      freq_in      = freq_ff;
      period_in    = period_ff;
      playing_in   = playing_ff;
      acc_in       = acc_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !res_ready;
      cmd_pop      = 1'b0;
      step_we      = 1'b0;
      q_we         = 1'b0;
      div_req      = '{start: 1'b0, dividend: clock_hz, divisor: rd_freq};
      unique case (state_ff)
         tsp_pkg::ST_IDLE: begin
            if (cmd_valid && !out_valid_ff) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_item;
               acc_in  = 1'b0;
            end
         end
         tsp_pkg::ST_EXEC: begin
            unique case (cmd_ff.cmd)
               tsp_pkg::CMD_TICK: begin
                  if (playing_ff) begin
                     rem_in = (rem_ff > 16'd1) ? rem_ff - 16'd1 : 16'd0;
                  end
               end
               tsp_pkg::CMD_WRITE: step_we = 1'b1;
               tsp_pkg::CMD_PLAY: begin
                  acc_in = 1'b1;
                  if (cmd_ff.mode == tsp_pkg::MODE_FORCE || !playing_ff) begin
                     // Force, or any play while idle, halts the running tone before the new sequence.
                     rem_in     = 16'd0;
                     freq_in    = 16'd0;
                     period_in  = 32'd0;
                     seq_in     = cmd_ff.start;
                     off_in     = 8'd0;
                     loop_in    = 16'd0;
                     playing_in = 1'b1;
                  end else if (cmd_ff.mode == tsp_pkg::MODE_QUEUE) begin
                     if (fill_ff < QFW'(QUEUE_DEPTH)) begin
                        q_we    = 1'b1;
                        tail_in = q_next(tail_ff);
                        fill_in = fill_ff + QFW'(1);
                     end else begin
                        acc_in = 1'b0;
                     end
                  end
               end
               tsp_pkg::CMD_STOP: begin
                  rem_in     = 16'd0;
                  freq_in    = 16'd0;
                  period_in  = 32'd0;
                  playing_in = 1'b0;
                  if (cmd_ff.clr) begin
                     head_in = '0;
                     tail_in = '0;
                     fill_in = '0;
                  end
               end
               default: step_we = 1'b0;
            endcase
         end
         tsp_pkg::ST_STEP_EX, tsp_pkg::ST_LOOP_EX: begin
            priority if (state_ff == tsp_pkg::ST_STEP_EX &&
                         (rd_action == tsp_pkg::STOP_CODE ||
                          (rd_action == tsp_pkg::LOOP_CODE && rd_freq != 16'd0 &&
                           loop_next == rd_freq))) begin
               if (rd_action == tsp_pkg::LOOP_CODE) loop_in = loop_next;
               freq_in    = 16'd0;
               period_in  = 32'd0;
               playing_in = 1'b0;
               rem_in     = 16'd0;
            end else if (state_ff == tsp_pkg::ST_STEP_EX &&
                         rd_action == tsp_pkg::LOOP_CODE) begin
               loop_in = loop_next;
               off_in  = 8'd0;
            end else begin
               // Play the step as a tone; after a loop the first step plays whatever its action code.
               freq_in       = rd_freq;
               off_in        = off_ff + 8'd1;
               rem_in        = rd_action;
               period_in     = 32'd0;
               div_req.start = (rd_freq != 16'd0);
            end
         end
         tsp_pkg::ST_QUEUE_EX: begin
            seq_in     = q_rdata;
            off_in     = 8'd0;
            loop_in    = 16'd0;
            playing_in = 1'b1;
            head_in    = q_next(head_ff);
            fill_in    = fill_ff - QFW'(1);
         end
         tsp_pkg::ST_DIVIDE: begin
            if (div_rsp.done) period_in = div_rsp.quotient;
         end
         tsp_pkg::ST_RESP: begin
            out_valid_in       = 1'b1;
            out_in.accepted    = acc_ff;
            out_in.busy        = playing_ff;
            out_in.tone_enable = (freq_ff != 16'd0);
            out_in.period      = period_ff;
            out_in.match       = period_ff[31:1];
            out_in.queued      = 4'(fill_ff);
         end
         default: step_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsp_pkg::ST_IDLE;
         seq_ff       <= 8'd0;
         off_ff       <= 8'd0;
         loop_ff      <= 16'd0;
         rem_ff       <= 16'd0;
         freq_ff      <= 16'd0;
         period_ff    <= 32'd0;
         playing_ff   <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         off_ff       <= off_in;
         loop_ff      <= loop_in;
         rem_ff       <= rem_in;
         freq_ff      <= freq_in;
         period_ff    <= period_in;
         playing_ff   <= playing_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff <= cmd_in;
      acc_ff <= acc_in;
      out_ff <= out_in;
   end

   assign res_valid = out_valid_ff;
   assign res_data  = out_ff;

   `TSP_ASSERT(a_fill_bound, clock, reset, fill_ff <= QFW'(QUEUE_DEPTH), "queue fill over depth")
   `TSP_ASSERT(a_resp_free, clock, reset, !(state_ff == tsp_pkg::ST_RESP && out_valid_ff), "result register overwritten")
   `TSP_ASSERT(a_div_idle, clock, reset, !(div_req.start && div_rsp.busy), "divider restarted while busy")
   `TSP_ASSERT_NEXT(a_div_wait, clock, reset, div_req.start, state_ff == tsp_pkg::ST_DIVIDE, "divide issued outside a tone step")
endmodule

// ----- rtl/core/tone_sequence_player_unit.sv -----
// Top level of the tone sequence player: ports, clock register, front and back.
// Depends on tsp_pkg, tsp_front and tsp_back.
//
// Channel  | Direction | Content
// req_*    | in        | command beat: tuser = cmd, tdata = request fields
// rsp_*    | out       | one result beat per command beat
// csr_*    | in        | write of the clock_hz register
//
// Commands run one at a time. A write step or a stop passes only through the execute and
// response states. A tick or play that starts a tone step waits for the serial
// divider that turns clock_hz into the PWM period; each finished sequence that
// pulls the next one from the start queue adds a queue read and another step read.
// The front accepts two more beats while one result waits in the output register.
// Reset is synchronous and active high; it clears sequencer state, not the memories.
module tone_sequence_player_unit #(
   parameter int STEP_DEPTH  = tsp_pkg::STEP_DEPTH_DEF,
   parameter int QUEUE_DEPTH = tsp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // play_mode[1:0], start_index[9:2], step_address[17:10], step_action[33:18],
   // step_freq[49:34], flush_queue[50], zero fill above
   input  logic [55:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // accepted[0], busy_res[1], tone_enable[2], tone_period[34:3], tone_match[65:35],
   // queued[69:66], zero fill above
   output logic [71:0] rsp_tdata
);
   logic [31:0] clock_hz_ff, clock_hz_in;
   logic cmd_valid, cmd_pop;
   tsp_pkg::cmd_type    cmd_item;
   tsp_pkg::result_type res;

   // The clock frequency is sampled only when a new tone is set.
   assign clock_hz_in = csr_wr_en ? csr_wr_data : clock_hz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= tsp_pkg::CLOCK_HZ_RESET;
      end else begin
         clock_hz_ff <= clock_hz_in;
      end
   end

   tsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd_item   (cmd_item)
   );

   tsp_back #(.STEP_DEPTH(STEP_DEPTH), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .clock_hz  (clock_hz_ff),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_item  (cmd_item),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res_data  (res)
   );

   assign rsp_tdata = {2'b00, res.queued, res.match, res.period,
                       res.tone_enable, res.busy, res.accepted};
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of tone_sequence_player_unit: directed table, then random traffic.
// Depends on tsp_pkg and the tone_sequence_player_unit RTL.
module testbench;
   typedef tsp_pkg::cmd_code_type cmd_code_type;
   typedef tsp_pkg::result_type   result_type;

   localparam cmd_code_type CMD_TICK  = tsp_pkg::CMD_TICK;
   localparam cmd_code_type CMD_WRITE = tsp_pkg::CMD_WRITE;
   localparam cmd_code_type CMD_PLAY  = tsp_pkg::CMD_PLAY;
   localparam cmd_code_type CMD_STOP  = tsp_pkg::CMD_STOP;
   localparam logic [1:0]   MODE_FORCE = tsp_pkg::MODE_FORCE;
   localparam logic [1:0]   MODE_QUEUE = tsp_pkg::MODE_QUEUE;
   localparam logic [15:0]  STOP_CODE  = tsp_pkg::STOP_CODE;
   localparam logic [15:0]  LOOP_CODE  = tsp_pkg::LOOP_CODE;

   // Play modes that the package does not name.
   localparam logic [1:0] MODE_IDLE_ONLY = 2'd2;
   localparam logic [1:0] MODE_ODD       = 2'd3;
   localparam int  CYCLE_LIMIT   = 3000000;
   localparam int  SETTLE_CYCLES = 120;
   localparam int  PHASE_ITEMS   = 115;

   // One row of the directed table; want is used only where typed is set.
   typedef struct packed {
      cmd_code_type cmd;
      logic [1:0]   mode;
      logic [7:0]   start;
      logic [7:0]   addr;
      logic [15:0]  action;
      logic [15:0]  freq;
      logic         clr;
      logic         typed;
      result_type   want;
   } script_row_type;

   localparam result_type QUIET = '0;

   // The table covers the extremes of duration, the lowest frequency, silence, a stop
   // step that hands over to a queued sequence, every play mode and both stops.
   script_row_type script [26] = '{
      '{CMD_TICK,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b1, QUIET},
      '{CMD_STOP,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1, 1'b1, QUIET},
      '{CMD_WRITE, MODE_FORCE, 8'd0, 8'd0, 16'd2, 16'd1000, 1'b0, 1'b1, QUIET},
      '{CMD_WRITE, MODE_FORCE, 8'd0, 8'd1, 16'd1, 16'd0, 1'b0, 1'b1, QUIET},
      '{CMD_WRITE, MODE_FORCE, 8'd0, 8'd2, 16'd0, 16'hFFFF, 1'b0, 1'b1, QUIET},
      '{CMD_WRITE, MODE_FORCE, 8'd0, 8'd3, LOOP_CODE, 16'd2, 1'b0, 1'b1, QUIET},
      '{CMD_WRITE, MODE_FORCE, 8'd0, 8'd4, STOP_CODE, 16'd12345, 1'b0, 1'b1, QUIET},
      '{CMD_WRITE, MODE_FORCE, 8'd0, 8'd255, 16'd65534, 16'd1, 1'b0, 1'b1, QUIET},
      '{CMD_WRITE, MODE_FORCE, 8'd0, 8'd5, LOOP_CODE, 16'd0, 1'b0, 1'b1, QUIET},
      '{CMD_PLAY,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b1,
        '{1'b1, 1'b1, 1'b1, 32'd80000, 31'd40000, 4'd0}},
      '{CMD_TICK,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_TICK,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_PLAY,  MODE_QUEUE, 8'd255, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_PLAY,  MODE_IDLE_ONLY, 8'd4, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_PLAY,  MODE_ODD, 8'd4, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_TICK,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_TICK,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_TICK,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_TICK,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_TICK,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_TICK,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_TICK,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_STOP,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_PLAY,  MODE_IDLE_ONLY, 8'd4, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_PLAY,  MODE_FORCE, 8'd255, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0, QUIET},
      '{CMD_STOP,  MODE_FORCE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1, 1'b0, QUIET}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = CMD_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   tone_sequence_player_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Shadow copy of the player state, kept in step with every accepted beat.
   logic [31:0] melody [256];
   logic [7:0]  waiting_starts [8];
   int unsigned wait_head, wait_tail, wait_count;
   logic [7:0]  tune_base, tune_pos;
   logic [15:0] loop_pass, ms_left, tone_hz;
   logic [31:0] pwm_load, clock_rate;
   bit          tune_active;

   result_type  expected_results [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   // Long receiver holds asked for by the main sequence and served by the receiver.
   int unsigned hold_asked = 0;
   int unsigned hold_given = 0;

   function automatic void set_pwm(input logic [15:0] hz);
      tone_hz  = hz;
      pwm_load = (hz != 0) ? clock_rate / hz : 32'd0;
   endfunction

   function automatic void open_tune(input logic [7:0] first);
      tune_base   = first;
      tune_pos    = 8'd0;
      loop_pass   = 16'd0;
      tune_active = 1'b1;
   endfunction

   // Moves on to the next tone step, following loops, stops and queued tunes.
   function automatic void next_note();
      logic [31:0] word;
      logic [15:0] act, hz;
      bit          done;
      for (int guard = 0; guard < 10; guard++) begin
         word = melody[8'(tune_base + tune_pos)];
         act  = word[15:0];
         hz   = word[31:16];
         done = 1'b0;
         if (act == STOP_CODE) begin
            done = 1'b1;
         end else if (act == LOOP_CODE) begin
            loop_pass = loop_pass + 16'd1;
            if (hz != 0 && loop_pass == hz) begin
               done = 1'b1;
            end else begin
               tune_pos = 8'd0;
               word = melody[tune_base];
               act  = word[15:0];
               hz   = word[31:16];
            end
         end
         if (done) begin
            set_pwm(16'd0);
            tune_active = 1'b0;
            ms_left = 16'd0;
            if (wait_count == 0) return;
            open_tune(waiting_starts[wait_head]);
            wait_head = (wait_head + 1) % 8;
            wait_count--;
         end else begin
            set_pwm(hz);
            tune_pos = tune_pos + 8'd1;
            ms_left = act;
            return;
         end
      end
   endfunction

   function automatic result_type player_response(input cmd_code_type c, input logic [1:0] m,
         input logic [7:0] first, input logic [7:0] addr, input logic [15:0] act,
         input logic [15:0] hz, input logic clr);
      result_type r;
      logic taken;
      taken = 1'b0;
      case (c)
         CMD_TICK: begin
            if (tune_active) begin
               if (ms_left > 1) begin
                  ms_left = ms_left - 16'd1;
               end else begin
                  ms_left = 16'd0;
                  next_note();
               end
            end
         end
         CMD_WRITE: melody[addr] = {hz, act};
         CMD_PLAY: begin
            if (m == MODE_FORCE) begin
               ms_left = 16'd0;
               set_pwm(16'd0);
               open_tune(first);
               next_note();
               taken = 1'b1;
            end else if (m == MODE_QUEUE && tune_active) begin
               if (wait_count < 8) begin
                  waiting_starts[wait_tail] = first;
                  wait_tail = (wait_tail + 1) % 8;
                  wait_count++;
                  taken = 1'b1;
               end
            end else begin
               taken = 1'b1;
               if (!tune_active) begin
                  open_tune(first);
                  next_note();
               end
            end
         end
         default: begin
            ms_left = 16'd0;
            set_pwm(16'd0);
            tune_active = 1'b0;
            if (clr) begin
               wait_head = 0;
               wait_tail = 0;
               wait_count = 0;
            end
         end
      endcase
      r.accepted    = taken;
      r.busy        = tune_active;
      r.tone_enable = (tone_hz != 0);
      r.period      = pwm_load;
      r.match       = pwm_load[31:1];
      r.queued      = 4'(wait_count);
      return r;
   endfunction

   // Offers one command beat and waits for it to be taken. The sender works in
   // bursts: between bursts valid usually drops for a random gap.
   task automatic send_command(input cmd_code_type c, input logic [1:0] m,
         input logic [7:0] first, input logic [7:0] addr, input logic [15:0] act,
         input logic [15:0] hz, input logic clr, input bit typed, input result_type want);
      result_type predicted;
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_tdata  <= {5'b0, clr, hz, act, addr, first, m};
      req_tuser  <= c;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = player_response(c, m, first, addr, act, hz, clr);
      expected_results.push_back(typed ? want : predicted);
   endtask

   // Lets every expected result arrive, then waits out any work still in flight.
   task automatic wait_until_drained();
      if (burst_left != 0 || req_tvalid) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
      end
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_clock_rate(input logic [31:0] rate);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rate;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      clock_rate = rate;
   endtask

   // A step word biased toward short, well-formed tunes that end in a stop or loop.
   function automatic logic [31:0] random_step();
      int unsigned pick;
      logic [15:0] act, hz;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         act = STOP_CODE;
         hz  = 16'($urandom);
      end else if (pick < 26) begin
         act = LOOP_CODE;
         hz  = 16'($urandom_range(0, 3));
      end else begin
         act = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 5));
         if (act == LOOP_CODE) act = 16'd3;
         pick = $urandom_range(0, 19);
         hz = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      end
      return {hz, act};
   endfunction

   task automatic random_traffic(input int unsigned count);
      int unsigned pick;
      logic [1:0]  m;
      logic [31:0] word;
      for (int unsigned n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         m    = 2'($urandom);
         word = random_step();
         if (pick < 55) begin
            send_command(CMD_TICK, m, 8'($urandom), 8'($urandom), 16'($urandom),
                         16'($urandom), 1'($urandom), 1'b0, QUIET);
         end else if (pick < 73) begin
            pick = $urandom_range(0, 9);
            m = (pick < 5) ? MODE_QUEUE : (pick < 7) ? MODE_FORCE :
                (pick < 9) ? MODE_IDLE_ONLY : MODE_ODD;
            send_command(CMD_PLAY, m, 8'($urandom), 8'($urandom), 16'($urandom),
                         16'($urandom), 1'($urandom), 1'b0, QUIET);
         end else if (pick < 88) begin
            send_command(CMD_WRITE, m, 8'($urandom), 8'($urandom), word[15:0],
                         word[31:16], 1'($urandom), 1'b0, QUIET);
         end else if (pick < 94) begin
            send_command(CMD_STOP, m, 8'($urandom), 8'($urandom), 16'($urandom),
                         16'($urandom), 1'($urandom), 1'b0, QUIET);
         end else begin
            // A run of queued plays, enough to overflow the start queue.
            for (int unsigned k = 0; k < 10; k++) begin
               send_command(CMD_PLAY, MODE_QUEUE, 8'($urandom), 8'($urandom),
                            16'($urandom), 16'($urandom), 1'b0, 1'b0, QUIET);
            end
            n += 9;
         end
      end
   endtask

   // Main sequence: reset, the directed table, a full fill of the step memory so
   // that no tune ever reads an unwritten entry, then random phases at several
   // clock rates.
   initial begin
      logic [31:0] word;
      logic [31:0] rates [4];
      rates = '{32'd1, 32'hFFFF_FFFF, 32'd80000000, 32'($urandom_range(1000, 200000000))};
      for (int i = 0; i < 256; i++) melody[i] = '0;
      for (int i = 0; i < 8; i++) waiting_starts[i] = '0;
      wait_head = 0;
      wait_tail = 0;
      wait_count = 0;
      tune_base = '0;
      tune_pos = '0;
      loop_pass = '0;
      ms_left = '0;
      tone_hz = '0;
      pwm_load = '0;
      tune_active = 1'b0;
      clock_rate = tsp_pkg::CLOCK_HZ_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         send_command(script[i].cmd, script[i].mode, script[i].start, script[i].addr,
                      script[i].action, script[i].freq, script[i].clr, script[i].typed,
                      script[i].want);
      end
      for (int a = 0; a < 256; a++) begin
         word = random_step();
         send_command(CMD_WRITE, MODE_FORCE, 8'd0, 8'(a), word[15:0], word[31:16],
                      1'b0, 1'b0, QUIET);
      end

      foreach (rates[p]) begin
         // The sender stops until every expected beat has come back.
         wait_until_drained();
         write_clock_rate(rates[p]);
         if (p == 1) hold_asked++;
         random_traffic(PHASE_ITEMS);
      end

      wait_until_drained();
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Receiver: switches between steady, patchy and mostly stalled stretches. On
   // request it holds off for a long stretch so that the block fills up and
   // back-pressures its input.
   int unsigned style = 0, style_left = 0, hold_left = 0;
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_given != hold_asked) begin
         hold_given = hold_asked;
         hold_left = 400;
         rsp_tready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            style = $urandom_range(0, 2);
            style_left = $urandom_range(20, 120);
         end
         style_left--;
         case (style)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom);
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // Checks each result beat against the oldest expectation.
   always @(posedge clock) begin
      result_type seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.accepted    = rsp_tdata[0];
         seen.busy        = rsp_tdata[1];
         seen.tone_enable = rsp_tdata[2];
         seen.period      = rsp_tdata[34:3];
         seen.match       = rsp_tdata[65:35];
         seen.queued      = rsp_tdata[69:66];
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result beat %h", rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (seen.accepted !== want.accepted || seen.busy !== want.busy ||
                seen.tone_enable !== want.tone_enable || seen.period !== want.period ||
                seen.match !== want.match || seen.queued !== want.queued) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch: expected acc %b busy %b en %b period %h match %h q %0d",
                           want.accepted, want.busy, want.tone_enable, want.period,
                           want.match, want.queued);
                  $display("          got      acc %b busy %b en %b period %h match %h q %0d",
                           seen.accepted, seen.busy, seen.tone_enable, seen.period,
                           seen.match, seen.queued);
               end
            end
         end
      end
   end

   // Watchdog for a block that hangs or loses beats.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tsp_pkg.sv
rtl/core/tsp_ram.sv
rtl/core/tsp_front.sv
rtl/core/tsp_div.sv
rtl/core/tsp_back.sv
rtl/core/tone_sequence_player_unit.sv
tb/sv/testbench.sv
